FILE: sv/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types and constants of the touch calibrate and stabilize block.
// ----------------------------------------------------------------------------
package tcs_pkg;

  // default geometry of the screen and the raw converter
  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 240;
  localparam int DEF_RAW_BITS      = 12;
  localparam int DEF_DIV_STEPS     = 9;

  // stability counter and tolerance
  localparam int COUNT_W = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
  localparam int TOL_W = 8;

  // register file
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_X_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOL      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDED   = 3'd5;

  // register reset values
  localparam int RST_X_LEFT   = 3857;
  localparam int RST_X_RIGHT  = 239;
  localparam int RST_Y_TOP    = 213;
  localparam int RST_Y_BOTTOM = 3693;
  localparam logic [TOL_W-1:0]   RST_TOL    = 8'd8;
  localparam logic [COUNT_W-1:0] RST_NEEDED = 8'd0;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the accepted word
    logic axis;     // 0 column, 1 row
    logic mul;      // offset and scale the selected axis
    logic pre;      // overflow check and divider load
    logic step;     // one quotient bit
    logic fin;      // clamp and store the axis result
    logic upd;      // stability update and result load
  } tcs_cmd_t;

endpackage

FILE: sv/tcs_ctrl.sv
// ----------------------------------------------------------------------------
// tcs_ctrl
// Sequencer: walks each touched sample through scale, divide and clamp, and every sample through the stability update.
// ----------------------------------------------------------------------------
module tcs_ctrl #(
  parameter int DIV_STEPS = tcs_pkg::DEF_DIV_STEPS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_touched_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output tcs_pkg::tcs_cmd_t cmd_o
);
  import tcs_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_PRE  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic             axis_q, axis_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    cnt_d       = cnt_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.axis  = axis_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          axis_d        = 1'b0;
          state_d       = in_touched_i ? S_MUL : S_UPD;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_PRE;
      end
      S_PRE: begin
        cmd_o.pre = 1'b1;
        cnt_d     = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        if (cnt_q == LAST_STEP) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = S_MUL;
        end else begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        // wait for the output register to be free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.upd = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output word valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.upd) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/tcs_datapath.sv
// ----------------------------------------------------------------------------
// tcs_datapath
// Calibration registers, shared scale and restoring divide unit, stability
// filter and output register.
// ----------------------------------------------------------------------------
module tcs_datapath #(
  parameter int SCREEN_WIDTH  = tcs_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = tcs_pkg::DEF_SCREEN_HEIGHT,
  parameter int RAW_BITS      = tcs_pkg::DEF_RAW_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [RAW_BITS-1:0]                   cfg_data_i,
  input  logic                                  touched_i,
  input  logic [RAW_BITS-1:0]                   raw_x_i,
  input  logic [RAW_BITS-1:0]                   raw_y_i,
  input  tcs_pkg::tcs_cmd_t                     cmd_i,
  output logic                                  pressed_o,
  output logic [$clog2(SCREEN_WIDTH)-1:0]       point_x_o,
  output logic [$clog2(SCREEN_HEIGHT)-1:0]      point_y_o
);
  import tcs_pkg::*;

  localparam int PX_W = $clog2(SCREEN_WIDTH);
  localparam int PY_W = $clog2(SCREEN_HEIGHT);
  localparam int QW   = (PX_W > PY_W) ? PX_W : PY_W;
  localparam int DW   = RAW_BITS + QW;
  localparam int SW   = RAW_BITS + 1;
  localparam int CWX  = (PX_W > TOL_W) ? PX_W : TOL_W;
  localparam int CWY  = (PY_W > TOL_W) ? PY_W : TOL_W;
  localparam logic [QW-1:0] X_MAX = QW'(SCREEN_WIDTH - 1);
  localparam logic [QW-1:0] Y_MAX = QW'(SCREEN_HEIGHT - 1);

  // calibration registers
  logic [RAW_BITS-1:0] x_left_q, x_right_q, y_top_q, y_bot_q;
  logic [TOL_W-1:0]    tol_q;
  logic [COUNT_W-1:0]  need_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_left_q  <= RAW_BITS'(RST_X_LEFT);
      x_right_q <= RAW_BITS'(RST_X_RIGHT);
      y_top_q   <= RAW_BITS'(RST_Y_TOP);
      y_bot_q   <= RAW_BITS'(RST_Y_BOTTOM);
      tol_q     <= RST_TOL;
      need_q    <= RST_NEEDED;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_X_LEFT:   x_left_q  <= cfg_data_i;
        REG_X_RIGHT:  x_right_q <= cfg_data_i;
        REG_Y_TOP:    y_top_q   <= cfg_data_i;
        REG_Y_BOTTOM: y_bot_q   <= cfg_data_i;
        REG_TOL:      tol_q     <= cfg_data_i[TOL_W-1:0];
        REG_NEEDED:   need_q    <= cfg_data_i[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // accepted sample
  logic                touched_q;
  logic [RAW_BITS-1:0] rx_q, ry_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      touched_q <= touched_i;
      rx_q      <= raw_x_i;
      ry_q      <= raw_y_i;
    end
  end

  // offset, sign handling and scale of the selected axis
  logic [RAW_BITS-1:0] raw_sel, at_zero, at_end, abs_num, abs_span;
  logic [SW-1:0]       num, span, num_neg_v, span_neg_v;
  logic [QW-1:0]       axis_max;
  logic [DW-1:0]       prod;
  logic                kill;

  always_comb begin
    raw_sel    = cmd_i.axis ? ry_q    : rx_q;
    at_zero    = cmd_i.axis ? y_top_q : x_left_q;
    at_end     = cmd_i.axis ? y_bot_q : x_right_q;
    axis_max   = cmd_i.axis ? Y_MAX   : X_MAX;
    num        = {1'b0, raw_sel} - {1'b0, at_zero};
    span       = {1'b0, at_end}  - {1'b0, at_zero};
    num_neg_v  = -num;
    span_neg_v = -span;
    abs_num    = num[SW-1]  ? num_neg_v[RAW_BITS-1:0]  : num[RAW_BITS-1:0];
    abs_span   = span[SW-1] ? span_neg_v[RAW_BITS-1:0] : span[RAW_BITS-1:0];
    prod       = DW'(abs_num) * DW'(axis_max);
    // a zero or negative quotient clamps to zero, as does an empty span
    kill       = (num == '0) || (span == '0) || (num[SW-1] ^ span[SW-1]);
  end

  // restoring divider
  logic [DW-1:0]       rem_q, dv_q;
  logic [RAW_BITS-1:0] span_q;
  logic [QW-1:0]       quo_q;
  logic                kill_q, ovf_q;
  logic                rem_ge;

  assign rem_ge = rem_q >= dv_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      rem_q  <= prod;
      span_q <= abs_span;
      kill_q <= kill;
    end else if (cmd_i.pre) begin
      ovf_q <= rem_q >= (DW'(span_q) << QW);
      dv_q  <= DW'(span_q) << (QW - 1);
      quo_q <= '0;
    end else if (cmd_i.step) begin
      if (rem_ge) begin
        rem_q <= rem_q - dv_q;
      end
      quo_q <= (quo_q << 1) | QW'(rem_ge);
      dv_q  <= dv_q >> 1;
    end
  end

  // clamp to the screen and store the axis result
  logic [QW-1:0]   axis_res;
  logic [PX_W-1:0] cx_q;
  logic [PY_W-1:0] cy_q;

  always_comb begin
    priority if (kill_q) begin
      axis_res = '0;
    end else if (ovf_q || quo_q > axis_max) begin
      axis_res = axis_max;
    end else begin
      axis_res = quo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      if (cmd_i.axis) begin
        cy_q <= axis_res[PY_W-1:0];
      end else begin
        cx_q <= axis_res[PX_W-1:0];
      end
    end
  end

  // stability filter
  logic [PX_W-1:0]    prev_x_q, held_x_q, dx;
  logic [PY_W-1:0]    prev_y_q, held_y_q, dy;
  logic [COUNT_W-1:0] count_q, count_inc, count_d;
  logic               stable, press;

  always_comb begin
    dx        = (cx_q >= prev_x_q) ? cx_q - prev_x_q : prev_x_q - cx_q;
    dy        = (cy_q >= prev_y_q) ? cy_q - prev_y_q : prev_y_q - cy_q;
    stable    = (CWX'(dx) < CWX'(tol_q)) && (CWY'(dy) < CWY'(tol_q));
    count_inc = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
    count_d   = stable ? count_inc : '0;
    press     = touched_q && (count_d >= need_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      held_x_q <= '0;
      held_y_q <= '0;
      count_q  <= '0;
    end else if (cmd_i.upd && touched_q) begin
      prev_x_q <= cx_q;
      prev_y_q <= cy_q;
      count_q  <= count_d;
      if (press) begin
        held_x_q <= cx_q;
        held_y_q <= cy_q;
      end
    end
  end

  // output word register
  logic            o_pressed_q;
  logic [PX_W-1:0] o_x_q;
  logic [PY_W-1:0] o_y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      o_pressed_q <= press;
      o_x_q       <= press ? cx_q : held_x_q;
      o_y_q       <= press ? cy_q : held_y_q;
    end
  end

  assign pressed_o = o_pressed_q;
  assign point_x_o = o_x_q;
  assign point_y_o = o_y_q;

endmodule

FILE: sv/touch_calibrate_and_stabilize.sv
// ----------------------------------------------------------------------------
// touch_calibrate_and_stabilize
// Two-point linear touch calibration with a stability filter.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis: tuser is the touched flag, tdata the raw X
// and Y readings. Each sample gives exactly one output word on m_axis:
// tuser is pressed, tdata the last stable screen column and row.
// The calibration points, move tolerance and stable count must be written on
// the cfg port while the block is idle; the block does not enforce this.
// A touched sample is scaled and divided one axis after the other through a
// shared restoring divider, one quotient bit a cycle: per axis a scale step,
// an overflow check, the divide steps and a clamp, then a stability update
// loads the output word. An untouched sample only runs the stability update.
// One sample is in work at a time; the next is taken the cycle after the
// output word is loaded, also while that word still waits.
// When the receiver stalls, a finished result waits in the stability update
// step until the output register frees. Reset restores the default
// calibration and clears the filter state and the output valid.
// ----------------------------------------------------------------------------
module touch_calibrate_and_stabilize #(
  parameter int SCREEN_WIDTH  = tcs_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = tcs_pkg::DEF_SCREEN_HEIGHT,
  parameter int RAW_BITS      = tcs_pkg::DEF_RAW_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [RAW_BITS-1:0]                 cfg_data_i,
  // sample stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((2*RAW_BITS+7)/8)*8-1:0]     s_axis_tdata,  // raw_x, raw_y
  input  logic                                s_axis_tuser,  // touched
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [(($clog2(SCREEN_WIDTH)+$clog2(SCREEN_HEIGHT)+7)/8)*8-1:0]
                                              m_axis_tdata,  // point_x, point_y
  output logic                                m_axis_tuser   // pressed
);
  import tcs_pkg::*;

  localparam int PX_W   = $clog2(SCREEN_WIDTH);
  localparam int PY_W   = $clog2(SCREEN_HEIGHT);
  localparam int QW     = (PX_W > PY_W) ? PX_W : PY_W;
  localparam int OUT_TW = ((PX_W + PY_W + 7) / 8) * 8;

  tcs_cmd_t        cmd;
  logic            pressed;
  logic [PX_W-1:0] point_x;
  logic [PY_W-1:0] point_y;

  // sequencer
  tcs_ctrl #(
    .DIV_STEPS(QW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_touched_i(s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  tcs_datapath #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .RAW_BITS     (RAW_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .touched_i (s_axis_tuser),
    .raw_x_i   (s_axis_tdata[RAW_BITS-1:0]),
    .raw_y_i   (s_axis_tdata[2*RAW_BITS-1:RAW_BITS]),
    .cmd_i     (cmd),
    .pressed_o (pressed),
    .point_x_o (point_x),
    .point_y_o (point_y)
  );

  // output packing
  assign m_axis_tdata = OUT_TW'({point_y, point_x});
  assign m_axis_tuser = pressed;

`ifndef ASSERT_OFF
  // an accepted word blocks further input until its result is loaded
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word accepted while a sample is in work");

  // a new result only follows a sample in work
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised without a sample in work");

  // reported point stays on the screen
  a_point_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[PX_W-1:0] <= PX_W'(SCREEN_WIDTH - 1)) &&
      (m_axis_tdata[PX_W+PY_W-1:PX_W] <= PY_W'(SCREEN_HEIGHT - 1)))
    else $error("reported point off the screen");
`endif

endmodule
